@@ rtl/cfs_pkg.sv @@
// shared constants, codes and types of the camera follow smoother
`default_nettype none

package cfs_pkg;

   // default fixed point layout
   localparam int FRAC_BITS_DEF  = 8;
   localparam int COORD_BITS_DEF = 16;

   // field and register widths
   localparam int OP_W       = 3;
   localparam int VIEW_W     = 13;
   localparam int SPEED_W    = 12;
   localparam int OUT_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // speed limit (10.0 with 8 fraction bits) and frame-rate divisor
   localparam int SPEED_MAX  = 2560;
   localparam int SPEED_DIV  = 60;

   // reset values of the configuration registers
   localparam int VIEW_W_RST = 640;
   localparam int VIEW_H_RST = 480;
   localparam int SPEED_RST  = 256;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_JUMP,
      OP_JUMP_CENTRED,
      OP_AIM,
      OP_AIM_CENTRED,
      OP_TICK
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_WIDTH,
      CSR_VIEW_HEIGHT,
      CSR_FOLLOW_SPEED
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_CHECK,
      ST_ROOT,
      ST_VMUL,
      ST_VDIV,
      ST_XMUL,
      ST_XDIV,
      ST_YMUL,
      ST_YDIV,
      ST_APPLY,
      ST_OUT
   } seq_state_type;

endpackage

`default_nettype wire

@@ rtl/cfs_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module cfs_divider #(
   parameter int N_W = 52,
   parameter int D_W = 26
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic [N_W-1:0] quotient,
   output logic           done
);
   localparam int CNT_W = $clog2(N_W + 1);

   logic [D_W:0]   rem_ff, rem_in;
   logic [N_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [D_W:0]   shifted;
   logic [D_W:0]   dsr_ext;

   // one restoring step per cycle
   always_comb begin
      shifted = {rem_ff[D_W-1:0], quo_ff[N_W-1]};
      dsr_ext = {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= dsr_ext) begin
            rem_in = shifted - dsr_ext;
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

@@ rtl/camera_follow_smoother.sv @@
// camera follow smoother: top level with sequencer, shared multiplier and root unit
//
// Requests arrive on the req_ stream: tuser carries the operation, tdata the
// coordinates. Each request gives exactly one response on the rsp_ stream
// with the camera position (saturated to 24 bits) and the settled flag.
// Jump, aim and unused codes go from idle straight to the output state, where
// the response is registered as the sequencer returns to idle.
// A tick runs a sequence over one shared multiplier, a two-bit-per-cycle
// square root and one bit-serial divider used for the two step components;
// the division by the speed divisor is a shift and a reciprocal multiply.
// A tick ends in the same output state; the root is 26 bits wide at the
// default layout, and the two step divisions take most of a tick's time.
// req_tready is high only while the sequencer is idle, one request at a time.
// A finished response sits in an output register; the next request may be
// accepted while it waits, and a further result then holds until rsp_tready.
// Configuration is written through csr_ with no wait. The user must write it
// only while idle; the block itself does not enforce this.
// Synchronous reset clears position, target and both streams, and restores
// view 640x480 and speed 1.0.
`default_nettype none

module camera_follow_smoother #(
   parameter int FRAC_BITS  = cfs_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = cfs_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // request: tdata = coord_x, coord_y, zero pad; tuser = operation
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic [cfs_pkg::OP_W-1:0]              req_tuser,
   // response: tdata = cam_x, cam_y, settled, zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*cfs_pkg::OUT_W+1+7)/8)*8-1:0] rsp_tdata,
   // configuration write port
   input  logic                                  csr_wen,
   input  logic [cfs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cfs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import cfs_pkg::*;

   localparam int CX_W   = ((COORD_BITS > VIEW_W) ? COORD_BITS : VIEW_W) + 1;
   localparam int P_W    = CX_W + FRAC_BITS;
   localparam int R_W    = P_W + 1;
   localparam int SQ_W   = 2 * R_W;
   localparam int MUL_W  = R_W + 2;
   localparam int MP_W   = 2 * MUL_W;
   localparam int RSP_W  = ((2*OUT_W+1+7)/8)*8;
   localparam int IT_W   = $clog2(SQ_W/2 + 1);
   localparam int CMP_W  = (P_W > OUT_W) ? P_W : OUT_W;
   // speed divisor split into an odd factor and a power of two
   localparam int DIV_ODD = SPEED_DIV / 4;
   localparam int DIV_SH  = FRAC_BITS + 2;
   localparam int RCP_SH  = R_W + 4;
   localparam logic [MUL_W-1:0] RCP =
      MUL_W'(((64'd1 << RCP_SH) + DIV_ODD - 1) / DIV_ODD);
   localparam logic [SQ_W-1:0] SNAP = SQ_W'(1) << (2*FRAC_BITS);
   localparam logic [R_W-1:0]  ONE  = R_W'(1) << FRAC_BITS;
   localparam logic signed [CMP_W-1:0] OUT_MAX = CMP_W'((2**(OUT_W-1)) - 1);
   localparam logic signed [CMP_W-1:0] OUT_MIN = -OUT_MAX - CMP_W'(1);

   seq_state_type state_ff, state_in;

   logic signed [P_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [P_W-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [VIEW_W-1:0]  view_w_ff, view_w_in, view_h_ff, view_h_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [P_W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic            neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [SQ_W-1:0] sq_ff, sq_in, rn_ff, rn_in, res_ff, res_in, bit_ff, bit_in;
   logic [IT_W-1:0] iter_ff, iter_in;
   logic [R_W-1:0]  root_ff, root_in, v_ff, v_in, vq_ff, vq_in;
   logic [SQ_W-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic            req_fire;
   op_type          op;
   logic signed [CX_W-1:0] cx, cy;
   logic signed [P_W:0] dx, dy;
   logic [MUL_W-1:0] mul_a, mul_b;
   logic [MP_W-1:0] mul_p;
   logic [SQ_W-1:0] trial, res_next;
   logic [R_W-1:0]  spd_lim;
   logic            div_start, div_done;
   logic [SQ_W-1:0] div_dividend, div_quotient;
   logic [R_W-1:0]  div_divisor;
   logic signed [CMP_W-1:0] px_ext, py_ext;
   logic [OUT_W-1:0] sat_x, sat_y;
   logic            settled;
   logic            out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = MUL_W'(ax_ff);
         end
         ST_SQY: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = MUL_W'(ay_ff);
         end
         ST_VMUL: begin
            mul_a = MUL_W'(root_ff);
            mul_b = MUL_W'(spd_lim);
         end
         ST_VDIV: begin
            mul_a = MUL_W'(vq_ff);
            mul_b = RCP;
         end
         ST_XMUL: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = MUL_W'(v_ff);
         end
         ST_YMUL: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = MUL_W'(v_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p   = MP_W'(mul_a) * MP_W'(mul_b);
   assign spd_lim = (speed_ff > SPEED_W'(SPEED_MAX)) ? R_W'(SPEED_MAX) : R_W'(speed_ff);

   // divider launch for the step components, fed straight from the multiplier
   assign div_start    = (state_ff == ST_XMUL) || (state_ff == ST_YMUL);
   assign div_dividend = SQ_W'(mul_p);
   assign div_divisor  = root_ff;

   cfs_divider #(
      .N_W (SQ_W),
      .D_W (R_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // request coordinates, optionally centred
   always_comb begin
      cx = CX_W'(signed'(req_tdata[COORD_BITS-1:0]));
      cy = CX_W'(signed'(req_tdata[2*COORD_BITS-1:COORD_BITS]));
      if (op inside {OP_JUMP_CENTRED, OP_AIM_CENTRED}) begin
         cx = cx - signed'(CX_W'(view_w_ff >> 1));
         cy = cy - signed'(CX_W'(view_h_ff >> 1));
      end
   end

   // deltas and one square-root step
   assign dx       = {goal_x_ff[P_W-1], goal_x_ff} - {pos_x_ff[P_W-1], pos_x_ff};
   assign dy       = {goal_y_ff[P_W-1], goal_y_ff} - {pos_y_ff[P_W-1], pos_y_ff};
   assign trial    = res_ff + bit_ff;
   assign res_next = (rn_ff >= trial) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire) state_in = (op == OP_TICK) ? ST_DIFF : ST_OUT;
         ST_DIFF:  state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_CHECK;
         ST_CHECK: state_in = (sq_ff <= SNAP) ? ST_OUT : ST_ROOT;
         ST_ROOT:  if (iter_ff == IT_W'(1)) state_in = ST_VMUL;
         ST_VMUL:  state_in = ST_VDIV;
         ST_VDIV:  state_in = ST_XMUL;
         ST_XMUL:  state_in = ST_XDIV;
         ST_XDIV:  if (div_done) state_in = ST_YMUL;
         ST_YMUL:  state_in = ST_YDIV;
         ST_YDIV:  if (div_done) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and register updates
   always_comb begin
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      sq_in     = sq_ff;
      rn_in     = rn_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      iter_in   = iter_ff;
      root_in   = root_ff;
      v_in      = v_ff;
      vq_in     = vq_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (op inside {OP_JUMP, OP_JUMP_CENTRED, OP_AIM,
                                        OP_AIM_CENTRED})) begin
               goal_x_in = {cx, {FRAC_BITS{1'b0}}};
               goal_y_in = {cy, {FRAC_BITS{1'b0}}};
               if (op inside {OP_JUMP, OP_JUMP_CENTRED}) begin
                  pos_x_in = {cx, {FRAC_BITS{1'b0}}};
                  pos_y_in = {cy, {FRAC_BITS{1'b0}}};
               end
            end
         end
         ST_DIFF: begin
            neg_x_in = dx[P_W];
            neg_y_in = dy[P_W];
            ax_in    = dx[P_W] ? P_W'(-dx) : P_W'(dx);
            ay_in    = dy[P_W] ? P_W'(-dy) : P_W'(dy);
         end
         ST_SQX: sq_in = SQ_W'(mul_p);
         ST_SQY: sq_in = sq_ff + SQ_W'(mul_p);
         ST_CHECK: begin
            if (sq_ff <= SNAP) begin
               pos_x_in = goal_x_ff;
               pos_y_in = goal_y_ff;
            end
            rn_in   = sq_ff;
            res_in  = '0;
            bit_in  = SQ_W'(1) << (SQ_W - 2);
            iter_in = IT_W'(SQ_W/2);
         end
         ST_ROOT: begin
            if (rn_ff >= trial) rn_in = rn_ff - trial;
            res_in  = res_next;
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff - IT_W'(1);
            root_in = (res_next == '0) ? R_W'(1) : res_next[R_W-1:0];
         end
         // drop the power-of-two part of the speed divisor
         ST_VMUL: vq_in = R_W'(mul_p >> DIV_SH);
         // odd part of the divisor by reciprocal multiply, floor of one pixel
         ST_VDIV: begin
            v_in = ((mul_p >> RCP_SH) < MP_W'(ONE)) ? ONE : R_W'(mul_p >> RCP_SH);
         end
         ST_XDIV: if (div_done) step_x_in = div_quotient;
         ST_YDIV: if (div_done) step_y_in = div_quotient;
         ST_APPLY: begin
            pos_x_in = neg_x_ff ? (pos_x_ff - signed'(step_x_ff[P_W-1:0]))
                                : (pos_x_ff + signed'(step_x_ff[P_W-1:0]));
            pos_y_in = neg_y_ff ? (pos_y_ff - signed'(step_y_ff[P_W-1:0]))
                                : (pos_y_ff + signed'(step_y_ff[P_W-1:0]));
         end
         default: begin
            pos_x_in = pos_x_ff;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      view_w_in = view_w_ff;
      view_h_in = view_h_ff;
      speed_in  = speed_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_VIEW_WIDTH:   view_w_in = csr_wdata[VIEW_W-1:0];
            CSR_VIEW_HEIGHT:  view_h_in = csr_wdata[VIEW_W-1:0];
            CSR_FOLLOW_SPEED: speed_in  = csr_wdata[SPEED_W-1:0];
            default:          view_w_in = view_w_ff;
         endcase
      end
   end

   // response formatting with output saturation
   always_comb begin
      px_ext  = CMP_W'(pos_x_ff);
      py_ext  = CMP_W'(pos_y_ff);
      sat_x   = (px_ext > OUT_MAX) ? OUT_W'(OUT_MAX) :
                (px_ext < OUT_MIN) ? OUT_W'(OUT_MIN) : px_ext[OUT_W-1:0];
      sat_y   = (py_ext > OUT_MAX) ? OUT_W'(OUT_MAX) :
                (py_ext < OUT_MIN) ? OUT_W'(OUT_MIN) : py_ext[OUT_W-1:0];
      settled = (pos_x_ff == goal_x_ff) && (pos_y_ff == goal_y_ff);
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (state_ff == ST_OUT && out_free) begin
         rsp_tdata_in  = RSP_W'({settled, sat_y, sat_x});
         rsp_tvalid_in = 1'b1;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         view_w_ff     <= VIEW_W'(VIEW_W_RST);
         view_h_ff     <= VIEW_W'(VIEW_H_RST);
         speed_ff      <= SPEED_W'(SPEED_RST);
         rsp_tvalid_ff <= 1'b0;
         iter_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         view_w_ff     <= view_w_in;
         view_h_ff     <= view_h_in;
         speed_ff      <= speed_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         iter_ff       <= iter_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      sq_ff        <= sq_in;
      rn_ff        <= rn_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      root_ff      <= root_in;
      v_ff         <= v_in;
      vq_ff        <= vq_in;
      step_x_ff    <= step_x_in;
      step_y_ff    <= step_y_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // divider only reports back while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_XDIV || state_ff == ST_YDIV))
      else $error("divider finished outside a wait state");

   // a step never overshoots the target
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |-> (step_x_ff <= SQ_W'(ax_ff)) && (step_y_ff <= SQ_W'(ay_ff)))
      else $error("step larger than remaining distance");

   // root of a distance past the snap radius is at least one pixel
   a_root_min: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VMUL |-> root_ff >= ONE)
      else $error("root below one pixel");

   // snapping leaves the camera settled
   a_snap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && sq_ff <= SNAP |=>
         pos_x_ff == goal_x_ff && pos_y_ff == goal_y_ff)
      else $error("snap did not reach target");

endmodule

`default_nettype wire

@@ tb/sv/camera_follow_smoother_test.sv @@
// testbench of the camera follow smoother: random and directed requests against a predictor
`timescale 1ns / 100ps

module camera_follow_smoother_test;
   import cfs_pkg::*;

   // codes with no operation behind them
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int RSP_W       = ((2*OUT_W+1+7)/8)*8;
   localparam int TICK_CYCLES = 400;
   localparam int WATCH_LIMIT = 5000;
   localparam int LONG_STALL  = 300;

   // position tracker and store of expected responses
   class follow_board;
      longint     pos_x, pos_y, goal_x, goal_y;
      longint     view_w, view_h, speed;
      logic [RSP_W-1:0] due_q[$];
      int         errors;

      function new();
         pos_x = 0; pos_y = 0; goal_x = 0; goal_y = 0;
         view_w = VIEW_W_RST; view_h = VIEW_H_RST; speed = SPEED_RST;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_VIEW_WIDTH:   view_w = val;
            CSR_VIEW_HEIGHT:  view_h = val;
            CSR_FOLLOW_SPEED: speed = val[SPEED_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      function longint unsigned int_root(longint unsigned n);
         longint unsigned res, bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > n) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      function longint step_part(longint delta, longint unsigned v, longint unsigned d);
         longint unsigned mg, m;
         mg = (delta < 0) ? longint'(-delta) : delta;
         m = mg * v / d;
         return (delta < 0) ? -longint'(m) : longint'(m);
      endfunction

      function logic [OUT_W-1:0] clip(longint v);
         longint hi, lo;
         hi = (64'sd1 <<< (OUT_W-1)) - 1;
         lo = -hi - 1;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return v[OUT_W-1:0];
      endfunction

      // one camera tick: move along the line or snap when close
      function void follow_tick();
         longint dx, dy;
         longint unsigned ax, ay, sq, d, v, spd;
         dx = goal_x - pos_x;
         dy = goal_y - pos_y;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         sq = ax*ax + ay*ay;
         if (sq <= (64'd1 << 16)) begin
            pos_x = goal_x;
            pos_y = goal_y;
            return;
         end
         d = int_root(sq);
         if (d == 0) d = 1;
         spd = (speed > SPEED_MAX) ? SPEED_MAX : speed;
         v = d * spd / (SPEED_DIV * 256);
         if (v < 256) v = 256;
         pos_x = pos_x + step_part(dx, v, d);
         pos_y = pos_y + step_part(dy, v, d);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [15:0] x,
                                 logic signed [15:0] y);
         longint cx, cy;
         cx = x;
         cy = y;
         if (op == OP_JUMP_CENTRED || op == OP_AIM_CENTRED) begin
            cx = cx - (view_w >> 1);
            cy = cy - (view_h >> 1);
         end
         if (op <= OP_AIM_CENTRED) begin
            goal_x = cx * 256;
            goal_y = cy * 256;
            if (op <= OP_JUMP_CENTRED) begin
               pos_x = goal_x;
               pos_y = goal_y;
            end
         end else if (op == OP_TICK) begin
            follow_tick();
         end
         due_q.push_back({7'd0, (pos_x == goal_x && pos_y == goal_y),
                          clip(pos_y), clip(pos_x)});
      endfunction

      function void check_response(logic [RSP_W-1:0] got);
         logic [RSP_W-1:0] want;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         want = due_q.pop_front();
         if (got[OUT_W-1:0] !== want[OUT_W-1:0] ||
             got[2*OUT_W-1:OUT_W] !== want[2*OUT_W-1:OUT_W] ||
             got[2*OUT_W] !== want[2*OUT_W]) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: cam_x %h/%h cam_y %h/%h settled %b/%b",
                  $time, want[OUT_W-1:0], got[OUT_W-1:0],
                  want[2*OUT_W-1:OUT_W], got[2*OUT_W-1:OUT_W],
                  want[2*OUT_W], got[2*OUT_W]);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   follow_board board = new();
   bit tx_calm = 0;
   bit rx_calm = 0;
   int stall_token = 0;
   int stall_seen = 0;
   int rx_hold = 0;
   int quiet = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   camera_follow_smoother u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // receiver: random stalls, long hold-off on demand
   always @(posedge clock) begin
      if (stall_token != stall_seen) begin
         stall_seen <= stall_token;
         rx_hold <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= rx_calm || ($urandom_range(99) >= 12);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet <= 0;
         end else if (quiet + 1 >= WATCH_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [15:0] x, logic [15:0] y);
      if (!tx_calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {y, x};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      board.set_reg(idx, val);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // stop offering and wait for every response, then let a tick wind down
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (TICK_CYCLES) @(posedge clock);
   endtask

   // coordinate near the current target pixel, or anywhere
   function automatic logic [15:0] pick_coord(longint goal);
      if ($urandom_range(99) < 30) return 16'($urandom);
      return 16'((goal >>> 8) + $urandom_range(0, 64) - 32);
   endfunction

   task automatic random_run(int count);
      int n;
      int r;
      logic [OP_W-1:0] op;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 55)      op = OP_TICK;
         else if (r < 70) op = OP_AIM;
         else if (r < 78) op = OP_AIM_CENTRED;
         else if (r < 88) op = OP_JUMP;
         else if (r < 95) op = OP_JUMP_CENTRED;
         else             op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         send_request(op, pick_coord(board.goal_x), pick_coord(board.goal_y));
      end
   endtask

   initial begin
      int ph;
      int vw[6];
      int vh[6];
      int sp[6];
      vw = '{640, 1, 4096, 0, 8191, 333};
      vh = '{480, 1, 4096, 0, 8191, 201};
      sp = '{256, 0, 2560, 4095, 1, 700};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (ph = 0; ph < 6; ph++) begin
         write_reg(CSR_VIEW_WIDTH, CSR_DATA_W'(vw[ph]));
         write_reg(CSR_VIEW_HEIGHT, CSR_DATA_W'(vh[ph]));
         write_reg(CSR_FOLLOW_SPEED, CSR_DATA_W'(sp[ph]));
         if (ph == 0) begin
            // directed: extremes, each operation, snap, saturation, spare codes
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_JUMP, 16'h7fff, 16'h8000);
            send_request(OP_AIM, 16'h8000, 16'h7fff);
            send_request(OP_TICK, 16'hffff, 16'hffff);
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_JUMP_CENTRED, 16'h8000, 16'h8000);
            send_request(OP_AIM_CENTRED, 16'h7fff, 16'h7fff);
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_JUMP, 16'd10, 16'd10);
            send_request(OP_AIM, 16'd11, 16'd10);
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_AIM, 16'd12, 16'd12);
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_SPARE_LO, 16'h1234, 16'h4321);
            send_request(OP_SPARE_LO + 3'd1, 16'h0, 16'h0);
            send_request(OP_SPARE_HI, 16'hffff, 16'hffff);
            send_request(OP_AIM_CENTRED, 16'd320, 16'd240);
            send_request(OP_TICK, 16'h0, 16'h0);
            send_request(OP_JUMP_CENTRED, 16'h0, 16'h0);
            send_request(OP_AIM, 16'h0, 16'h0);
            send_request(OP_TICK, 16'h0, 16'h0);
         end
         if (ph == 2) begin
            // long receiver hold-off while requests keep coming
            stall_token <= stall_token + 1;
            random_run(10);
         end
         if (ph == 3) begin
            random_run(100);
            drain();
            tx_calm = 1;
            rx_calm = 1;
            random_run(60);
            tx_calm = 0;
            rx_calm = 0;
         end
         random_run(180);
         drain();
      end
      if (board.pending() == 0 && board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
